// File: hw/rtl/fifo_reuse_id_allocator_defines.svh
// Assertion macros for the fifo_reuse_id_allocator block.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef FIFO_REUSE_ID_ALLOCATOR_DEFINES_SVH
`define FIFO_REUSE_ID_ALLOCATOR_DEFINES_SVH

// checked only outside reset
`define FRA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define FRA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/fra_pkg.sv
// Shared types and constants for the fifo_reuse_id_allocator block.
// No dependencies; used by fra_cell, fra_enc and the top level.
package fra_pkg;

  localparam int TOP_COLOR = 255;
  localparam int ID_BASE   = 2;
  localparam int SLOTS     = TOP_COLOR - ID_BASE + 1;

  localparam int ID_W    = $clog2(TOP_COLOR + 1);
  localparam int POS_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int GRANT_W = 8;
  localparam int RID_W   = 8;
  localparam int STAT_W  = 2;

  // hit encoder: groups of GRP cells, registered per group
  localparam int GRP    = 16;
  localparam int GRP_W  = $clog2(GRP);
  localparam int NGRP   = (SLOTS + GRP - 1) / GRP;
  localparam int NGRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int HIT_W  = NGRP * GRP;
  localparam int ENC_W  = NGRP_W + GRP_W;
  localparam int PW     = (CNT_W > ENC_W) ? CNT_W : ENC_W;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_REUSE   = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTUSED = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROT,
    CELL_INS
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [PW-1:0]     fc;
    logic [PW-1:0]     pos;
    logic [ID_W-1:0]   rid;
  } ctrl_t;

endpackage

// File: hw/rtl/fra_cell.sv
// One list slot of the id allocator: holds one id and shifts with its neighbors.
// Depends on fra_pkg.
module fra_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [fra_pkg::POS_W-1:0] slot_i,
  input  fra_pkg::ctrl_t            ctrl_i,
  input  logic [fra_pkg::ID_W-1:0]  prev_id_i,
  input  logic [fra_pkg::ID_W-1:0]  next_id_i,
  output logic [fra_pkg::ID_W-1:0]  id_o,
  output logic                      hit_o
);

  logic [fra_pkg::ID_W-1:0] id_q, id_d;
  logic [fra_pkg::PW-1:0]   sp;

  assign sp = fra_pkg::PW'(slot_i);

  always_comb begin
    id_d = id_q;
    case (ctrl_i.op)
      fra_pkg::CELL_ROT: begin
        id_d = next_id_i;
      end
      fra_pkg::CELL_INS: begin
        if (sp == ctrl_i.fc) begin
          id_d = ctrl_i.rid;
        end else if (sp > ctrl_i.fc && sp <= ctrl_i.pos) begin
          id_d = prev_id_i;
        end
      end
      default: begin
        id_d = id_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q <= fra_pkg::ID_W'(slot_i) + fra_pkg::ID_W'(fra_pkg::ID_BASE);
    end else begin
      id_q <= id_d;
    end
  end

  // used region starts at the free count
  assign hit_o = (id_q == ctrl_i.rid) && (sp >= ctrl_i.fc);
  assign id_o  = id_q;

endmodule

// File: hw/rtl/fra_enc.sv
// Registered one-hot to index encoder for one group of cell hit flags.
// Depends on fra_pkg.
module fra_enc (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [fra_pkg::GRP-1:0]   hit_i,
  output logic                      any_o,
  output logic [fra_pkg::GRP_W-1:0] idx_o
);

  logic                      any_q;
  logic [fra_pkg::GRP_W-1:0] idx_q, idx_d;

  always_comb begin
    idx_d = '0;
    for (int i = 0; i < fra_pkg::GRP; i++) begin
      if (hit_i[i]) begin
        idx_d = idx_d | fra_pkg::GRP_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q <= 1'b0;
    end else begin
      any_q <= |hit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  assign any_o = any_q;
  assign idx_o = idx_q;

endmodule

// File: hw/rtl/fifo_reuse_id_allocator.sv
// Top level of the FIFO-order id allocator: control, free count and the row of cells.
// Depends on fra_pkg, fra_cell, fra_enc and fifo_reuse_id_allocator_defines.svh.
//
// Usage:
//   Input stream (s_axis): one word per request. tuser[0] = mode (0 allocate,
//   1 release), tdata[7:0] = released_id. Output stream (m_axis): one word per
//   request, tdata[7:0] = granted_id, tdata[9:8] = status.
//   Ids 2..TOP_COLOR sit in a row of cells, free ids first, used ids after in
//   allocation order. Allocate rotates the row by one cell in the accept cycle;
//   its result is registered and valid on the next cycle.
//   A release in range searches the row (S_LOC), encodes the hit through the
//   registered group encoders (S_ENC, result shown then) and moves the id
//   to the end of the free region (S_MOVE). An out of range id is answered
//   from S_IDLE; an id not in use returns to S_IDLE after S_ENC.
//   One request is worked at a time. A finished result waits in the output
//   register; a new word is taken when that register is empty or drained in
//   the same cycle, so a stalled receiver holds the input off.
//   Reset loads ids in ascending order, all free, and empties the output.
`include "fifo_reuse_id_allocator_defines.svh"

module fifo_reuse_id_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] released_id
  input  logic [0:0]  s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] granted_id, [9:8] status, [15:10] zero
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOC  = 2'd1;
  localparam logic [1:0] S_ENC  = 2'd2;
  localparam logic [1:0] S_MOVE = 2'd3;

  logic [1:0]                         state_q, state_d;
  logic [fra_pkg::CNT_W-1:0]          fc_q, fc_d;
  logic [fra_pkg::ID_W-1:0]           rid_q, rid_d;
  logic [fra_pkg::ENC_W-1:0]          pos_q, pos_d;
  logic                               m_valid_q, m_valid_d;
  logic [fra_pkg::GRANT_W-1:0]        m_grant_q, m_grant_d;
  logic [fra_pkg::STAT_W-1:0]         m_stat_q, m_stat_d;

  fra_pkg::ctrl_t                     ctrl;
  logic [fra_pkg::ID_W-1:0]           id_w [fra_pkg::SLOTS];
  logic [fra_pkg::SLOTS-1:0]          hit_w;
  logic [fra_pkg::HIT_W-1:0]          hit_pad;
  logic [fra_pkg::NGRP-1:0]           grp_any;
  logic [fra_pkg::GRP_W-1:0]          grp_idx [fra_pkg::NGRP];
  logic [fra_pkg::ENC_W-1:0]          enc_pos;
  logic                               enc_found;
  logic                               s_acc, m_fire, rid_bad;
  logic [fra_pkg::CNT_W-1:0]          fc_inc;
  logic                               in_move, alloc_free, out_ok;

  assign s_axis_tready = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_valid_q && m_axis_tready;
  assign rid_bad       = (int'(s_axis_tdata) < fra_pkg::ID_BASE) ||
                         (int'(s_axis_tdata) > fra_pkg::TOP_COLOR);

  // cell row
  for (genvar p = 0; p < fra_pkg::SLOTS; p++) begin : g_cell
    logic [fra_pkg::ID_W-1:0] prev_id, next_id;
    if (p == 0) begin : g_first
      assign prev_id = '0;
    end else begin : g_mid
      assign prev_id = id_w[p-1];
    end
    if (p == fra_pkg::SLOTS - 1) begin : g_last
      assign next_id = id_w[0];
    end else begin : g_body
      assign next_id = id_w[p+1];
    end
    fra_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .slot_i    (fra_pkg::POS_W'(p)),
      .ctrl_i    (ctrl),
      .prev_id_i (prev_id),
      .next_id_i (next_id),
      .id_o      (id_w[p]),
      .hit_o     (hit_w[p])
    );
  end

  assign hit_pad = fra_pkg::HIT_W'(hit_w);

  for (genvar g = 0; g < fra_pkg::NGRP; g++) begin : g_enc
    fra_enc u_enc (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .hit_i  (hit_pad[g*fra_pkg::GRP +: fra_pkg::GRP]),
      .any_o  (grp_any[g]),
      .idx_o  (grp_idx[g])
    );
  end

  always_comb begin
    enc_pos   = '0;
    enc_found = 1'b0;
    for (int g = 0; g < fra_pkg::NGRP; g++) begin
      if (grp_any[g]) begin
        enc_pos   = enc_pos | fra_pkg::ENC_W'(g * fra_pkg::GRP) |
                    fra_pkg::ENC_W'(grp_idx[g]);
        enc_found = 1'b1;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    fc_d      = fc_q;
    rid_d     = rid_q;
    pos_d     = pos_q;
    m_valid_d = m_valid_q && !m_fire;
    m_grant_d = m_grant_q;
    m_stat_d  = m_stat_q;
    ctrl.op   = fra_pkg::CELL_HOLD;
    ctrl.fc   = fra_pkg::PW'(fc_q);
    ctrl.pos  = fra_pkg::PW'(pos_q);
    ctrl.rid  = rid_q;
    case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          if (s_axis_tuser[0] == fra_pkg::MODE_ALLOC) begin
            ctrl.op   = fra_pkg::CELL_ROT;
            m_valid_d = 1'b1;
            m_grant_d = fra_pkg::GRANT_W'(id_w[0]);
            if (fc_q == '0) begin
              m_stat_d = fra_pkg::ST_REUSE;
            end else begin
              m_stat_d = fra_pkg::ST_OK;
              fc_d     = fc_q - 1'b1;
            end
          end else if (rid_bad) begin
            m_valid_d = 1'b1;
            m_grant_d = '0;
            m_stat_d  = fra_pkg::ST_RANGE;
          end else begin
            rid_d   = fra_pkg::ID_W'(s_axis_tdata);
            state_d = S_LOC;
          end
        end
      end
      S_LOC: begin
        state_d = S_ENC;
      end
      S_ENC: begin
        pos_d     = enc_pos;
        m_valid_d = 1'b1;
        m_grant_d = '0;
        m_stat_d  = enc_found ? fra_pkg::ST_OK : fra_pkg::ST_NOTUSED;
        state_d   = enc_found ? S_MOVE : S_IDLE;
      end
      S_MOVE: begin
        ctrl.op = fra_pkg::CELL_INS;
        fc_d    = fc_q + 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fc_q      <= fra_pkg::CNT_W'(fra_pkg::SLOTS);
      rid_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fc_q      <= fc_d;
      rid_q     <= rid_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    m_grant_q <= m_grant_d;
    m_stat_q  <= m_stat_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, m_stat_q, m_grant_q};

  assign fc_inc     = fc_q + 1'b1;
  assign in_move    = (state_q == S_MOVE);
  assign alloc_free = s_acc && (s_axis_tuser[0] == fra_pkg::MODE_ALLOC) && (fc_q != '0);
  assign out_ok     = m_valid_q && (m_stat_q == fra_pkg::ST_OK);

  `FRA_ASSERT(a_fc_bound, clk_i, rst_ni, (int'(fc_q) <= fra_pkg::SLOTS), "free count too large")
  `FRA_ASSERT(a_hit_unique, clk_i, rst_ni, $onehot0(hit_w), "release id found in two cells")
  `FRA_ASSERT(a_move_inc, clk_i, rst_ni, in_move |=> fc_q == $past(fc_inc), "free count not grown")
  `FRA_ASSERT(a_alloc_ok, clk_i, rst_ni, alloc_free |=> out_ok, "allocate with free ids not ok")

endmodule
